>>> rtl/core/rwlm_pkg.sv
// ============================================================================
// rwlm_pkg: shared types and constants of the region weighted luma meter
// Field widths, register indexes and the request type that travels from the
// pixel classifier to the accumulator.
// ============================================================================
package rwlm_pkg;

    localparam int LUMA_BITS      = 8;
    localparam int DIM_BITS       = 12;
    localparam int PCT_BITS       = 7;
    localparam int MEAN_BITS      = 16;
    localparam int SUM_BITS       = 32;
    localparam int COUNT_BITS     = 25;
    localparam int CFG_INDEX_BITS = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FOCUS_WEIGHT = 2'd2;

    // One classified pixel
    typedef struct packed {
        logic [LUMA_BITS-1:0] luma;      // full-range value
        logic                 in_window; // pixel lies in the focus window
        logic                 clear;     // first pixel of a frame
        logic                 last;      // last pixel of a frame
    } pix_req_t;

endpackage

>>> rtl/core/rwlm_front.sv
// ============================================================================
// rwlm_front: pixel classifier
// Tracks column and row, latches the focus window bounds, expands luma to
// full range and tags each pixel with its region and frame marks.
// ============================================================================
module rwlm_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rwlm_pkg::DIM_BITS-1:0]     frame_width,
    input  logic [rwlm_pkg::DIM_BITS-1:0]     frame_height,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rwlm_pkg::LUMA_BITS-1:0]    luma,
    input  logic                              frame_start,
    output logic                              push,
    output rwlm_pkg::pix_req_t                push_req,
    input  logic                              queue_full
);

    localparam int XW = (COORD_BITS > rwlm_pkg::DIM_BITS) ? COORD_BITS : rwlm_pkg::DIM_BITS;
    localparam logic [XW-1:0] COORD_MAX = XW'((1 << COORD_BITS) - 1);
    localparam int RECIP_SHIFT = 17;
    localparam int PW = COORD_BITS + 1 + RECIP_SHIFT;
    localparam logic [14:0] DIV5_MUL  = 15'd26215;
    localparam logic [14:0] DIV10_MUL = 15'd13108;

    // floor((v-16)*255/219) clamped to 255; /219 by reciprocal 2^24 scale
    function automatic logic [rwlm_pkg::LUMA_BITS-1:0] expand(
        input logic [rwlm_pkg::LUMA_BITS-1:0] v
    );
        logic [15:0] scaled;
        logic [32:0] prod;
        logic [8:0]  q;
        scaled = 16'(v - 8'd16) * 16'd255;
        prod   = 33'(scaled) * 33'd76609;
        q      = prod[32:24];
        if (v <= 8'd16)
        begin
            expand = '0;
        end
        else if (q > 9'd255)
        begin
            expand = 8'd255;
        end
        else
        begin
            expand = q[7:0];
        end
    endfunction

    logic [COORD_BITS-1:0] column_reg, column_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    logic [XW-1:0]         w_ext, h_ext;
    logic [COORD_BITS-1:0] w_eff, h_eff;
    logic [PW-1:0]         fw_prod, fh_prod, gap_prod;
    logic [COORD_BITS-1:0] fw, fh, gap, nx1, nx2, ny1, ny2;
    logic [COORD_BITS-1:0] col_cur, row_cur, cx1, cx2, cy1, cy2;
    logic                  in_window, row_end, frame_end, relatch;

    always_comb
    begin
        w_ext = XW'(frame_width);
        h_ext = XW'(frame_height);
        w_eff = (w_ext > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] : w_ext[COORD_BITS-1:0];
        h_eff = (h_ext > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] : h_ext[COORD_BITS-1:0];
    end

    // Window bounds from the current dimensions (constant divides by reciprocal)
    always_comb
    begin
        fw_prod  = PW'({w_eff, 1'b0}) * PW'(DIV5_MUL);
        fh_prod  = PW'({h_eff, 1'b0}) * PW'(DIV5_MUL);
        gap_prod = PW'(h_eff) * PW'(DIV10_MUL);
        fw  = fw_prod[RECIP_SHIFT +: COORD_BITS];
        fh  = fh_prod[RECIP_SHIFT +: COORD_BITS];
        gap = gap_prod[RECIP_SHIFT +: COORD_BITS];
        nx1 = COORD_BITS'((w_eff - fw) >> 1);
        nx2 = nx1 + fw;
        ny2 = h_eff - gap;
        ny1 = ny2 - fh;
    end

    always_comb
    begin
        col_cur   = frame_start ? '0 : column_reg;
        row_cur   = frame_start ? '0 : row_reg;
        cx1       = frame_start ? nx1 : x1_reg;
        cx2       = frame_start ? nx2 : x2_reg;
        cy1       = frame_start ? ny1 : y1_reg;
        cy2       = frame_start ? ny2 : y2_reg;
        in_window = (col_cur >= cx1) && (col_cur < cx2) &&
                    (row_cur >= cy1) && (row_cur < cy2);
        row_end   = ({1'b0, col_cur} + 1'b1) >= {1'b0, w_eff};
        frame_end = row_end && (({1'b0, row_cur} + 1'b1) >= {1'b0, h_eff});
        relatch   = push && (frame_start || frame_end);
    end

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_req.luma      = expand(luma);
        push_req.in_window = in_window;
        push_req.clear     = frame_start;
        push_req.last      = frame_end;
    end

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (push)
        begin
            if (row_end)
            begin
                column_next = '0;
                row_next    = frame_end ? '0 : COORD_BITS'(row_cur + 1'b1);
            end
            else
            begin
                column_next = COORD_BITS'(col_cur + 1'b1);
                row_next    = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            x1_reg     <= '0;
            x2_reg     <= '0;
            y1_reg     <= '0;
            y2_reg     <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            if (relatch)
            begin
                x1_reg <= nx1;
                x2_reg <= nx2;
                y1_reg <= ny1;
                y2_reg <= ny2;
            end
        end
    end

endmodule

>>> rtl/core/rwlm_queue.sv
// ============================================================================
// rwlm_queue: request queue
// Short first-in first-out buffer between the classifier and the accumulator.
// ============================================================================
module rwlm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rwlm_pkg::pix_req_t  push_req,
    output logic                full,
    output logic                head_valid,
    output rwlm_pkg::pix_req_t  head_req,
    input  logic                pop
);

    rwlm_pkg::pix_req_t                  slot_reg [rwlm_pkg::QUEUE_DEPTH];
    logic [rwlm_pkg::QPTR_BITS-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [rwlm_pkg::QCNT_BITS-1:0]      count_reg;

    assign full       = (count_reg == rwlm_pkg::QCNT_BITS'(rwlm_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/rwlm_back.sv
// ============================================================================
// rwlm_back: accumulator and result sequencer
// Sums luma and counts pixels per region; at frame end snapshots the totals,
// runs two shared restoring divisions and the weighted blend.
// ============================================================================
module rwlm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rwlm_pkg::PCT_BITS-1:0]     focus_weight_pct,
    input  logic                              head_valid,
    input  rwlm_pkg::pix_req_t                head_req,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rwlm_pkg::MEAN_BITS-1:0]    weighted_luma,
    output logic [rwlm_pkg::MEAN_BITS-1:0]    focus_mean,
    output logic [rwlm_pkg::MEAN_BITS-1:0]    background_mean
);

    localparam int SB = rwlm_pkg::SUM_BITS;
    localparam int CB = rwlm_pkg::COUNT_BITS;
    localparam int MB = rwlm_pkg::MEAN_BITS;
    localparam int DQ_BITS   = SB + 8;
    localparam int STEP_BITS = $clog2(DQ_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DQ_BITS - 1);
    localparam int PROD_BITS  = MB + rwlm_pkg::PCT_BITS;
    localparam int DIV100_SH  = 30;
    localparam int SCALE_BITS = PROD_BITS + 24;
    localparam logic [23:0] DIV100_MUL = 24'd10737419;
    localparam logic [rwlm_pkg::PCT_BITS-1:0] PCT_FULL = 7'd100;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIVF  = 3'd1;
    localparam logic [2:0] S_DIVB  = 3'd2;
    localparam logic [2:0] S_BLEND = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;

    logic [2:0]           state_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 out_valid_reg;
    logic [SB-1:0]        fsum_reg, bsum_reg, snap_bsum_reg;
    logic [CB-1:0]        fcnt_reg, bcnt_reg, snap_bcnt_reg, divisor_reg;
    logic [DQ_BITS-1:0]   dq_reg;
    logic [CB-1:0]        rem_reg;
    logic [MB-1:0]        fm_reg, bm_reg, blend_reg;
    logic [PROD_BITS-1:0] prod_reg;

    logic                 busy, pop_last;
    logic [SB-1:0]        fsum_add, bsum_add;
    logic [CB-1:0]        fcnt_add, bcnt_add;
    logic [CB:0]          rem_sh;
    logic                 ge;
    logic [CB-1:0]        rem_step;
    logic [DQ_BITS-1:0]   dq_step;
    logic [MB-1:0]        mean_q;
    logic [rwlm_pkg::PCT_BITS-1:0] pct_sat;
    logic [SCALE_BITS-1:0] scale_prod;

    // Hold a frame-end request until the previous result has left
    assign busy     = (state_reg != S_IDLE) || out_valid_reg;
    assign pop      = head_valid && !(head_req.last && busy);
    assign pop_last = pop && head_req.last;

    always_comb
    begin
        fsum_add = (head_req.clear ? '0 : fsum_reg) +
                   (head_req.in_window ? SB'(head_req.luma) : '0);
        bsum_add = (head_req.clear ? '0 : bsum_reg) +
                   (head_req.in_window ? '0 : SB'(head_req.luma));
        fcnt_add = (head_req.clear ? '0 : fcnt_reg) + CB'(head_req.in_window);
        bcnt_add = (head_req.clear ? '0 : bcnt_reg) + CB'(!head_req.in_window);
    end

    // One restoring division step
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[DQ_BITS-1]};
        ge       = rem_sh >= {1'b0, divisor_reg};
        rem_step = ge ? CB'(rem_sh - {1'b0, divisor_reg}) : rem_sh[CB-1:0];
        dq_step  = {dq_reg[DQ_BITS-2:0], ge};
        if (divisor_reg == '0)
        begin
            mean_q = '0;
        end
        else if (dq_step[DQ_BITS-1:MB] != '0)
        begin
            mean_q = '1;
        end
        else
        begin
            mean_q = dq_step[MB-1:0];
        end
    end

    assign pct_sat    = (focus_weight_pct > PCT_FULL) ? PCT_FULL : focus_weight_pct;
    assign scale_prod = SCALE_BITS'(prod_reg) * SCALE_BITS'(DIV100_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            fsum_reg      <= '0;
            bsum_reg      <= '0;
            fcnt_reg      <= '0;
            bcnt_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                fsum_reg <= head_req.last ? '0 : fsum_add;
                bsum_reg <= head_req.last ? '0 : bsum_add;
                fcnt_reg <= head_req.last ? '0 : fcnt_add;
                bcnt_reg <= head_req.last ? '0 : bcnt_add;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop_last)
                    begin
                        state_reg <= S_DIVF;
                        step_reg  <= '0;
                    end
                end
                S_DIVF:
                begin
                    step_reg <= (step_reg == LAST_STEP) ? '0 : step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= S_DIVB;
                    end
                end
                S_DIVB:
                begin
                    step_reg <= (step_reg == LAST_STEP) ? '0 : step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= S_BLEND;
                    end
                end
                S_BLEND:
                begin
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (pop_last)
                begin
                    dq_reg        <= {fsum_add, 8'd0};
                    rem_reg       <= '0;
                    divisor_reg   <= fcnt_add;
                    snap_bsum_reg <= bsum_add;
                    snap_bcnt_reg <= bcnt_add;
                end
            end
            S_DIVF:
            begin
                if (step_reg == LAST_STEP)
                begin
                    fm_reg      <= mean_q;
                    dq_reg      <= {snap_bsum_reg, 8'd0};
                    rem_reg     <= '0;
                    divisor_reg <= snap_bcnt_reg;
                end
                else
                begin
                    dq_reg  <= dq_step;
                    rem_reg <= rem_step;
                end
            end
            S_DIVB:
            begin
                if (step_reg == LAST_STEP)
                begin
                    bm_reg <= mean_q;
                end
                else
                begin
                    dq_reg  <= dq_step;
                    rem_reg <= rem_step;
                end
            end
            S_BLEND:
            begin
                prod_reg <= PROD_BITS'(fm_reg) * PROD_BITS'(pct_sat) +
                            PROD_BITS'(bm_reg) * PROD_BITS'(PCT_FULL - pct_sat);
            end
            S_SCALE:
            begin
                blend_reg <= scale_prod[DIV100_SH +: MB];
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign weighted_luma   = blend_reg;
    assign focus_mean      = fm_reg;
    assign background_mean = bm_reg;

    // A pending result never overlaps a running computation
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while a frame is being computed");

    // The focus division hands over to the background division
    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVF && step_reg == LAST_STEP) |=> (state_reg == S_DIVB))
        else $error("background division did not follow focus division");

    // A result appears only out of the scaling step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_SCALE))
        else $error("result raised outside the scaling step");

endmodule

>>> rtl/core/region_weighted_luma_meter.sv
// ============================================================================
// region_weighted_luma_meter: center weighted exposure meter
// Measures mean full-range luma of a focus window and of the background per
// frame and blends them by a programmable percent weight, in Q8.8.
// ============================================================================
//
//  channel   direction  handshake          payload
//  -------   ---------  -----------------  --------------------------------
//  s_*       in         s_tvalid/s_tready  tdata: luma; tuser: frame_start
//  m_*       out        m_tvalid/m_tready  tdata: weighted, focus, background
//  cfg_*     in         cfg_we (no wait)   cfg_index, cfg_data
//
//  One pixel a clock is taken while the four-entry request queue has room,
//  and the accumulator drains one request a clock unless a frame-end request is held.
//  The last pixel of a frame starts two 40-step divisions, then the blend and
//  scale steps; pixels of the next frame keep flowing meanwhile, and
//  only the next frame-end request waits until the result has been taken.
//  A stalled result holds in the output register; a full queue drops s_tready.
//  Reset clears counters, window bounds, sums and the queue and loads the
//  registers with 640, 480 and 80.
//
module region_weighted_luma_meter #(
    parameter int COORD_BITS = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration write port
    input  logic                                    cfg_we,
    input  logic [rwlm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [rwlm_pkg::DIM_BITS-1:0]           cfg_data,
    // pixel stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [7:0]                              s_tdata,  // [7:0] luma
    input  logic                                    s_tuser,  // [0] frame_start
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [15:0] weighted_luma, [31:16] focus_mean, [47:32] background_mean
    output logic [47:0]                             m_tdata
);

    logic [rwlm_pkg::DIM_BITS-1:0]  frame_width_reg;
    logic [rwlm_pkg::DIM_BITS-1:0]  frame_height_reg;
    logic [rwlm_pkg::PCT_BITS-1:0]  focus_weight_reg;

    logic                           push, queue_full, head_valid, pop;
    rwlm_pkg::pix_req_t             push_req, head_req;
    logic [rwlm_pkg::MEAN_BITS-1:0] weighted_luma, focus_mean, background_mean;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 12'd640;
            frame_height_reg <= 12'd480;
            focus_weight_reg <= 7'd80;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rwlm_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                rwlm_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                rwlm_pkg::REG_FOCUS_WEIGHT:
                begin
                    focus_weight_reg <= cfg_data[rwlm_pkg::PCT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Classify each pixel: position, region and frame marks
    rwlm_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .luma         (s_tdata[rwlm_pkg::LUMA_BITS-1:0]),
        .frame_start  (s_tuser),
        .push         (push),
        .push_req     (push_req),
        .queue_full   (queue_full)
    );

    // Decouple classification from accumulation and result math
    rwlm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (push_req),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop)
    );

    // Accumulate, divide and blend
    rwlm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .focus_weight_pct (focus_weight_reg),
        .head_valid       (head_valid),
        .head_req         (head_req),
        .pop              (pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .weighted_luma    (weighted_luma),
        .focus_mean       (focus_mean),
        .background_mean  (background_mean)
    );

    assign m_tdata = {background_mean, focus_mean, weighted_luma};

endmodule
